FILE: rtl/rrd_pkg.sv
// rrd_pkg: shared types and codes for the row record decoder
// result kinds, register indexes, controller command and status structs
// no dependencies
package rrd_pkg;

  localparam int COL_W   = 5;   // column counter, holds 0..16
  localparam int KIND_W  = 3;
  localparam int WORD_W  = 32;
  localparam int BYTE_W  = 8;
  localparam int BMAP_W  = 16;
  localparam int CFG_W   = 16;
  localparam int OUT_W   = 80;  // output tdata, padded to whole bytes

  // result kinds
  localparam logic [KIND_W-1:0] KIND_NULL   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INT    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SSTART = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SBYTE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 3'd4;

  // configuration register indexes
  localparam logic REG_COLUMN_COUNT = 1'b0;
  localparam logic REG_INT_MASK     = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic              bmap_lo;   // store low bitmap byte
    logic              bmap_hi;   // store high bitmap byte
    logic              asm_we;    // store field byte at asm_pos
    logic [1:0]        asm_pos;
    logic              rem_load;  // load string byte count
    logic              rem_dec;
    logic              col_clear;
    logic              col_inc;
    logic              emit;      // write a result into the output register
    logic [KIND_W-1:0] kind;
    logic              col_done;
    logic              row_done;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;      // output register can take a result this cycle
    logic cc_zero;       // row has no columns
    logic first_present; // column 0 present in the stored bitmap
    logic col_in_range;  // current column below column count
    logic cur_present;   // current column present
    logic next_present;  // following column present
    logic row_end;       // current column is the last one of the row
    logic is_int;        // current column is an integer
    logic word_zero;     // assembled word is zero
    logic rem_last;      // last string byte
  } ctl_stat_t;

endpackage

FILE: rtl/row_record_decoder.sv
// row_record_decoder: top level of the serialized row decoder
// joins rrd_ctrl and rrd_datapath; depends on rrd_pkg
//
// Usage
//   s_axis carries the row stream, one byte per word in s_axis_tdata. A row
//   is a 16-bit little-endian null bitmap, then for each present column a
//   4-byte little-endian integer or a 4-byte length and that many bytes.
//   m_axis carries one result per word: kind in m_axis_tuser, row end in
//   m_axis_tlast, the other fields in m_axis_tdata.
//   cfg_we / cfg_index / cfg_data write the column count (index 0, saturated
//   to MAX_COLUMNS) and integer_column_mask (index 1) between rows.
// Timing
//   One input byte a cycle while the receiver takes results and no null
//   result is being emitted; a result appears in the output register in
//   the cycle after its byte is taken. Each null column emits one null
//   result with s_axis_tready low; the next column's bytes follow at once.
// Reset
//   rst clears configuration to zero and returns to waiting for a bitmap.
//   When m_axis_tready is low the held result stays and input stops.
module row_record_decoder #(
  parameter int MAX_COLUMNS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rrd_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] record_byte
  input  logic [rrd_pkg::BYTE_W-1:0]    s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [3:0] column_index, [35:4] integer_value, [67:36] string_length,
  // [75:68] string_byte, [76] column_done, [79:77] zero
  output logic [rrd_pkg::OUT_W-1:0]     m_axis_tdata,
  // [2:0] result_kind
  output logic [rrd_pkg::KIND_W-1:0]    m_axis_tuser,
  // row_done
  output logic                          m_axis_tlast
);
  import rrd_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  rrd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_tvalid (s_axis_tvalid),
    .in_tready (s_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rrd_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_byte    (s_axis_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (m_axis_tvalid),
    .out_tready (m_axis_tready),
    .out_tdata  (m_axis_tdata),
    .out_tuser  (m_axis_tuser),
    .out_tlast  (m_axis_tlast)
  );

endmodule

FILE: rtl/rrd_ctrl.sv
// rrd_ctrl: row parsing state machine
// walks bitmap, field bytes, string bytes and null runs; drives rrd_datapath
// depends on rrd_pkg
module rrd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  rrd_pkg::ctl_stat_t stat,
  output rrd_pkg::ctl_cmd_t  cmd
);
  import rrd_pkg::*;

  localparam logic [2:0] ST_BM0    = 3'd0;
  localparam logic [2:0] ST_BM1    = 3'd1;
  localparam logic [2:0] ST_FIELD  = 3'd2;
  localparam logic [2:0] ST_STRING = 3'd3;
  localparam logic [2:0] ST_ADV    = 3'd4;

  logic [2:0] state, state_next;
  logic [1:0] pos, pos_next;
  logic       take;

  assign in_tready = (state != ST_ADV) && stat.out_free;
  assign take      = in_tvalid && in_tready;

  // state and byte position registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_BM0;
      pos   <= 2'd0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    pos_next      = pos;
    cmd           = '0;
    cmd.asm_pos   = pos;
    cmd.kind      = KIND_NULL;
    unique case (state)
      ST_BM0: begin
        if (take) begin
          cmd.bmap_lo = 1'b1;
          state_next  = ST_BM1;
        end
      end
      ST_BM1: begin
        if (take) begin
          cmd.bmap_hi   = 1'b1;
          cmd.col_clear = 1'b1;
          if (stat.cc_zero) begin
            cmd.emit     = 1'b1;
            cmd.kind     = KIND_EMPTY;
            cmd.row_done = 1'b1;
            state_next   = ST_BM0;
          end else if (stat.first_present) begin
            state_next = ST_FIELD;
          end else begin
            state_next = ST_ADV;
          end
          pos_next = 2'd0;
        end
      end
      ST_FIELD: begin
        if (take) begin
          if (pos != 2'd3) begin
            cmd.asm_we = 1'b1;
            pos_next   = pos + 2'd1;
          end else begin
            pos_next = 2'd0;
            cmd.emit = 1'b1;
            if (stat.is_int || stat.word_zero) begin
              // column completes on this word
              cmd.kind      = stat.is_int ? KIND_INT : KIND_SSTART;
              cmd.col_done  = 1'b1;
              cmd.row_done  = stat.row_end;
              cmd.col_clear = stat.row_end;
              cmd.col_inc   = !stat.row_end;
              state_next    = stat.row_end ? ST_BM0 :
                              (stat.next_present ? ST_FIELD : ST_ADV);
            end else begin
              cmd.kind     = KIND_SSTART;
              cmd.rem_load = 1'b1;
              state_next   = ST_STRING;
            end
          end
        end
      end
      ST_STRING: begin
        if (take) begin
          cmd.rem_dec = 1'b1;
          cmd.emit    = 1'b1;
          cmd.kind    = KIND_SBYTE;
          if (stat.rem_last) begin
            cmd.col_done  = 1'b1;
            cmd.row_done  = stat.row_end;
            cmd.col_clear = stat.row_end;
            cmd.col_inc   = !stat.row_end;
            state_next    = stat.row_end ? ST_BM0 :
                            (stat.next_present ? ST_FIELD : ST_ADV);
          end
        end
      end
      ST_ADV: begin
        // one null result per cycle while the output register is free, until a present column or the row end
        if (!stat.col_in_range) begin
          cmd.col_clear = 1'b1;
          state_next    = ST_BM0;
        end else if (stat.cur_present) begin
          state_next = ST_FIELD;
        end else if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.kind      = KIND_NULL;
          cmd.col_done  = 1'b1;
          cmd.row_done  = stat.row_end;
          cmd.col_clear = stat.row_end;
          cmd.col_inc   = !stat.row_end;
          state_next    = stat.row_end ? ST_BM0 :
                          (stat.next_present ? ST_FIELD : ST_ADV);
        end
      end
      default: begin
        state_next = ST_BM0;
      end
    endcase
  end

endmodule

FILE: rtl/rrd_datapath.sv
// rrd_datapath: configuration, bitmap, column counter, field assembly,
// string byte counter and the output register
// depends on rrd_pkg
module rrd_datapath #(
  parameter int MAX_COLUMNS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [rrd_pkg::CFG_W-1:0]      cfg_data,
  input  logic [rrd_pkg::BYTE_W-1:0]     in_byte,
  input  rrd_pkg::ctl_cmd_t              cmd,
  output rrd_pkg::ctl_stat_t             stat,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [rrd_pkg::OUT_W-1:0]      out_tdata,
  output logic [rrd_pkg::KIND_W-1:0]     out_tuser,
  output logic                           out_tlast
);
  import rrd_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS + 1);

  logic [CW-1:0]      col_limit;
  logic [BMAP_W-1:0]  int_mask;
  logic [BMAP_W-1:0]  bitmap;
  logic [COL_W-1:0]   col;
  logic [23:0]        asm_word;
  logic [WORD_W-1:0]  rem;
  logic [WORD_W-1:0]  word;
  logic [COL_W-1:0]   cc5;
  logic [COL_W-1:0]   col_nxt;

  // output register fields
  logic [3:0]         o_col;
  logic [KIND_W-1:0]  o_kind;
  logic [WORD_W-1:0]  o_ival;
  logic [WORD_W-1:0]  o_slen;
  logic [BYTE_W-1:0]  o_sbyte;
  logic               o_cdone;
  logic               o_rdone;

  // configuration registers, column count saturates
  always_ff @(posedge clk) begin
    if (rst) begin
      col_limit <= '0;
      int_mask  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMN_COUNT: begin
          col_limit <= (cfg_data[4:0] > 5'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS)
                                                         : CW'(cfg_data[4:0]);
        end
        REG_INT_MASK: int_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // row state
  always_ff @(posedge clk) begin
    if (rst) begin
      bitmap <= '0;
      col    <= '0;
      rem    <= '0;
    end else begin
      if (cmd.bmap_lo) bitmap <= {8'h00, in_byte};
      if (cmd.bmap_hi) bitmap[15:8] <= in_byte;
      if (cmd.col_clear)    col <= '0;
      else if (cmd.col_inc) col <= col_nxt;
      if (cmd.rem_load)     rem <= word;
      else if (cmd.rem_dec) rem <= rem - WORD_W'(1);
    end
  end

  // low three bytes of a field word
  always_ff @(posedge clk) begin
    if (cmd.asm_we) begin
      case (cmd.asm_pos)
        2'd0:    asm_word[7:0]   <= in_byte;
        2'd1:    asm_word[15:8]  <= in_byte;
        default: asm_word[23:16] <= in_byte;
      endcase
    end
  end

  assign word    = {in_byte, asm_word};
  assign cc5     = COL_W'(col_limit);
  assign col_nxt = col + COL_W'(1);

  // status to the controller
  always_comb begin
    stat.out_free      = !out_tvalid || out_tready;
    stat.cc_zero       = (col_limit == '0);
    stat.first_present = bitmap[0];
    stat.col_in_range  = (col < cc5);
    stat.cur_present   = (col < cc5) && bitmap[col[3:0]];
    stat.next_present  = (col_nxt < cc5) && bitmap[col_nxt[3:0]];
    stat.row_end       = (col_nxt >= cc5);
    stat.is_int        = int_mask[col[3:0]];
    stat.word_zero     = (word == '0);
    stat.rem_last      = (rem == WORD_W'(1));
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_col   <= (cmd.kind == KIND_EMPTY) ? 4'd0 : col[3:0];
      o_kind  <= cmd.kind;
      o_ival  <= (cmd.kind == KIND_INT) ? word : '0;
      o_slen  <= (cmd.kind == KIND_SSTART) ? word : '0;
      o_sbyte <= (cmd.kind == KIND_SBYTE) ? in_byte : '0;
      o_cdone <= cmd.col_done;
      o_rdone <= cmd.row_done;
    end
  end

  assign out_tdata = {3'b000, o_cdone, o_sbyte, o_slen, o_ival, o_col};
  assign out_tuser = o_kind;
  assign out_tlast = o_rdone;

endmodule
